/* rtl/core/tfst_pkg.sv */
// Package for the TCP flow slot table: slot sizing, TCP flag codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tfst_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int KEY_W     = 48;

	localparam logic [7:0] FL_SYN    = 8'h02;
	localparam logic [7:0] FL_SYNACK = 8'h12;
	localparam logic [7:0] FL_ACK    = 8'h10;
	localparam logic [7:0] FL_FINACK = 8'h11;

	localparam logic [2:0] SEEN_SYN    = 3'h1;
	localparam logic [2:0] SEEN_SYNACK = 3'h2;
	localparam logic [2:0] SEEN_ACK    = 3'h4;
	localparam logic [2:0] SEEN_ALL    = 3'h7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRC,
		ST_OPEN,
		ST_DST,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;       // latch the accepted header
		logic src_match;  // compare source key, run handshake tracker
		logic open;       // bind a slot if the handshake completed
		logic dst_match;  // compare destination key
		logic finish;     // apply close, load output register
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

/* rtl/core/tcp_flow_slot_table_core.sv */
// Top level of the TCP flow slot table: joins controller and datapath.
// Depends on tfst_pkg, tfst_ctrl and tfst_dp.
//
// Usage:
//   s_axis carries one parsed packet header per transfer; s_axis_tuser holds
//   is_tcp, s_axis_tdata the header fields. m_axis returns exactly one result
//   per header, in order. cfg_wen/cfg_wdata write server_port; the user must
//   write server_port only while idle, the block does not enforce this. The
//   header is accepted in the idle state, then the controller steps through
//   source-key match, slot open, destination-key match and finish, and only
//   then takes the next header. The key compare over all slots runs once per
//   match step and is registered. m_axis_tvalid rises once the finish step
//   has loaded the output register.
//   The result sits in an output register; when m_axis_tready is low the
//   block holds it. One more header may still be accepted and worked up to
//   the finish step, which waits, with s_axis_tready low, until the held
//   result has been transferred.
//   Reset (arst_n low) empties the table, refills the free list with slots in
//   ascending order, disarms the handshake tracker and sets server_port to 0.
module tcp_flow_slot_table_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: tcp_flags[7:0], src_ip[39:8], src_tcp_port[55:40], dst_ip[87:56],
	//        dst_port[103:88]
	input  logic [103:0] s_axis_tdata,
	// tuser: is_tcp[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: forward[0], slot_id[4:1], opened[5], closed[6], close_missed[7],
	//        table_full[8], zero[15:9]
	output logic [15:0]  m_axis_tdata
);
	import tfst_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tfst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tfst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_is_tcp (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

/* rtl/core/tfst_ctrl.sv */
// Controller for the TCP flow slot table: steps one header through
// source match, open, destination match and finish. Depends on tfst_pkg.
module tfst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tfst_pkg::stat_t stat,
	output tfst_pkg::cmd_t  cmd
);
	import tfst_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_SRC;
			end
			ST_SRC:  state_n = ST_OPEN;
			ST_OPEN: state_n = ST_DST;
			ST_DST:  state_n = ST_FIN;
			ST_FIN: begin
				// hold until the previous result has been taken
				if (stat.out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SRC:  cmd.src_match = 1'b1;
			ST_OPEN: cmd.open      = 1'b1;
			ST_DST:  cmd.dst_match = 1'b1;
			ST_FIN:  cmd.finish    = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* rtl/core/tfst_dp.sv */
// Datapath for the TCP flow slot table: header latch, handshake tracker,
// slot key table, free-slot FIFO and output register. Depends on tfst_pkg.
module tfst_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wen,
	input  logic [15:0]     cfg_wdata,
	input  logic            in_is_tcp,
	input  logic [103:0]    in_data,
	input  tfst_pkg::cmd_t  cmd,
	output tfst_pkg::stat_t stat,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [15:0]     out_data
);
	import tfst_pkg::*;

	function automatic logic [SLOT_W-1:0] first_idx(input logic [NUM_SLOTS-1:0] vec);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (vec[i]) idx = SLOT_W'(i);
		end
		return idx;
	endfunction

	logic [15:0]          server_port_q;
	logic                 is_tcp_q;
	logic [7:0]           flags_q;
	logic [KEY_W-1:0]     src_key_q;
	logic [KEY_W-1:0]     dst_key_q;
	logic [15:0]          src_tcp_port_q;

	logic                 armed_q, armed_n;
	logic [2:0]           seen_q, seen_n;
	logic                 done_q, done_n;

	logic [KEY_W-1:0]     key_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] in_use_q;
	logic [SLOT_W-1:0]    free_q [NUM_SLOTS];
	logic [SLOT_W-1:0]    head_q;
	logic [CNT_W-1:0]     count_q;

	logic [NUM_SLOTS-1:0] match;
	logic [NUM_SLOTS-1:0] src_match_q;
	logic [NUM_SLOTS-1:0] dst_match_q;
	logic [KEY_W-1:0]     cmp_key;

	logic                 out_valid_q;
	logic [15:0]          out_data_q;

	logic [SLOT_W-1:0]    pop_id;
	logic [SLOT_W-1:0]    head_next;
	logic [CNT_W:0]       tail_sum;
	logic [SLOT_W-1:0]    tail;
	logic                 dst_hit;
	logic [SLOT_W-1:0]    dst_idx;
	logic                 close_cond;
	logic                 fwd;
	logic [3:0]           slot_out;

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_port_q <= '0;
		end else if (cfg_wen) begin
			server_port_q <= cfg_wdata;
		end
	end

	// header latch: flags[7:0], src_ip[39:8], src_tcp_port[55:40], dst_ip[87:56],
	// dst_port[103:88]
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_tcp_q       <= in_is_tcp;
			flags_q        <= in_data[7:0];
			src_key_q      <= in_data[55:8];
			src_tcp_port_q <= in_data[55:40];
			dst_key_q      <= in_data[103:56];
		end
	end

	// handshake tracker
	always_comb begin
		armed_n = armed_q;
		seen_n  = seen_q;
		done_n  = 1'b0;
		if (is_tcp_q) begin
			if (flags_q == FL_SYN) begin
				armed_n = 1'b1;
				seen_n  = SEEN_SYN;
			end else if (armed_q) begin
				if (flags_q == FL_SYNACK) begin
					seen_n = seen_q | SEEN_SYNACK;
				end else if (flags_q == FL_ACK) begin
					done_n  = ((seen_q | SEEN_ACK) == SEEN_ALL);
					armed_n = 1'b0;
					seen_n  = '0;
				end else begin
					armed_n = 1'b0;
					seen_n  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			seen_q  <= '0;
		end else if (cmd.src_match) begin
			armed_q <= armed_n;
			seen_q  <= seen_n;
		end
	end

	// key compare lanes, one per slot
	assign cmp_key = cmd.dst_match ? dst_key_q : src_key_q;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			match[i] = in_use_q[i] && (key_q[i] == cmp_key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.src_match) begin
			src_match_q <= match;
			done_q      <= done_n;
		end
		if (cmd.dst_match) begin
			dst_match_q <= match;
		end
	end

	assign pop_id    = free_q[head_q];
	assign head_next = (head_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	always_comb begin
		if (tail_sum >= (CNT_W+1)'(NUM_SLOTS)) begin
			tail = SLOT_W'(tail_sum - (CNT_W+1)'(NUM_SLOTS));
		end else begin
			tail = SLOT_W'(tail_sum);
		end
	end

	assign dst_hit    = |dst_match_q;
	assign dst_idx    = first_idx(dst_match_q);
	assign close_cond = is_tcp_q && (flags_q == FL_FINACK) && (src_tcp_port_q == server_port_q);
	// a close removes the only binding of the destination key
	assign fwd        = is_tcp_q && dst_hit && !close_cond;
	assign slot_out   = fwd ? 4'(dst_idx) : 4'd0;

	logic open_go;
	assign open_go = cmd.open && is_tcp_q && done_q && !(|src_match_q);

	always_ff @(posedge clk) begin
		if (open_go && (count_q != '0)) begin
			key_q[pop_id] <= src_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			head_q   <= '0;
			count_q  <= CNT_W'(NUM_SLOTS);
			for (int i = 0; i < NUM_SLOTS; i++) begin
				free_q[i] <= SLOT_W'(i);
			end
		end else begin
			if (open_go && (count_q != '0)) begin
				in_use_q[pop_id] <= 1'b1;
				head_q           <= head_next;
				count_q          <= count_q - 1'b1;
			end
			if (cmd.finish && close_cond && dst_hit) begin
				in_use_q[dst_idx] <= 1'b0;
				if (count_q < CNT_W'(NUM_SLOTS)) begin
					free_q[tail] <= dst_idx;
					count_q      <= count_q + 1'b1;
				end
			end
		end
	end

	// result flags for the finish step
	logic opened_q, full_q;
	always_ff @(posedge clk) begin
		if (cmd.src_match) begin
			opened_q <= 1'b0;
			full_q   <= 1'b0;
		end else if (open_go) begin
			opened_q <= (count_q != '0);
			full_q   <= (count_q == '0);
		end
	end

	// output register: forward[0], slot_id[4:1], opened[5], closed[6],
	// close_missed[7], table_full[8]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= {7'd0, full_q, close_cond && !dst_hit, close_cond && dst_hit,
				opened_q, slot_out, fwd};
		end
	end

endmodule

/* rtl/core/tfst_checker.sv */
// Port-level checker for the TCP flow slot table, bound to the top level.
// Depends on tcp_flow_slot_table_core.
module tfst_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [15:0]  m_axis_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// one header in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("header accepted while another is in work");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0({m_axis_tdata[5], m_axis_tdata[8]}) &&
			$onehot0({m_axis_tdata[6], m_axis_tdata[7]}))
		else $error("conflicting result flags");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == 4'd0)
		else $error("slot_id set without forward");

	// a closed key is no longer bound, so it cannot forward
	a_close_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6] |-> !m_axis_tdata[0])
		else $error("forward on a closing packet");

endmodule

bind tcp_flow_slot_table_core tfst_checker u_tfst_checker (.*);
